// ===== src/etf_pkg.sv =====
package etf_pkg;
  localparam int QW = 32;
  localparam int FRAC = 24;
  localparam int IDX_W = 11;
  localparam int CNT_W = 12;
  localparam int STEP_W = 31;
  localparam int NCELL = 4;
  localparam int REG_W = 3;
  localparam int DATA_W = 40;
  localparam logic signed [63:0] LIMIT = 64'sd32 <<< FRAC;

  localparam logic [REG_W-1:0] R_MODE = 3'd0;
  localparam logic [REG_W-1:0] R_MAXIT = 3'd1;
  localparam logic [REG_W-1:0] R_JRE = 3'd2;
  localparam logic [REG_W-1:0] R_JIM = 3'd3;
  localparam logic [REG_W-1:0] R_ORE = 3'd4;
  localparam logic [REG_W-1:0] R_OIM = 3'd5;
  localparam logic [REG_W-1:0] R_SRE = 3'd6;
  localparam logic [REG_W-1:0] R_SIM = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [CNT_W-1:0] n;
    logic signed [QW-1:0] a;
    logic signed [QW-1:0] b;
    logic signed [QW-1:0] cre;
    logic signed [QW-1:0] cim;
    logic done;
  } tok_t;

  function automatic logic signed [QW-1:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[QW-1:0];
  endfunction
endpackage

// ===== src/etf_cell.sv =====
module etf_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  etf_pkg::tok_t tok_i,
  input  logic [etf_pkg::CNT_W-1:0] max_it,
  output logic          vld_o,
  output etf_pkg::tok_t tok_o
);
  import etf_pkg::*;
  // stage 1: squares and cross product
  logic vld1_r;
  tok_t t1_r;
  logic signed [QW-1:0] aa_r, bb_r, ab2_r;
  logic signed [63:0] paa, pbb, pab, qaa, qbb;
  logic signed [65:0] na, nb, mag;
  logic go;
  tok_t t_nxt;

  assign paa = 64'(tok_i.a) * 64'(tok_i.a);
  assign pbb = 64'(tok_i.b) * 64'(tok_i.b);
  assign pab = 64'(tok_i.a) * 64'(tok_i.b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
    t1_r <= tok_i;
    aa_r <= sat(66'(paa >>> FRAC));
    bb_r <= sat(66'(pbb >>> FRAC));
    ab2_r <= sat(66'(pab >>> (FRAC - 1)));
  end

  // stage 2: update, magnitude and stop test
  assign qaa = 64'(aa_r) * 64'(aa_r);
  assign qbb = 64'(bb_r) * 64'(bb_r);
  assign mag = 66'(sat(66'(qaa >>> FRAC))) + 66'(sat(66'(qbb >>> FRAC)));
  assign na = 66'(aa_r) - 66'(bb_r) + 66'(t1_r.cre);
  assign nb = 66'(ab2_r) + 66'(t1_r.cim);

  always_comb begin
    t_nxt = t1_r;
    go = 1'b0;
    if (!t1_r.done) begin
      t_nxt.a = sat(na);
      t_nxt.b = sat(nb);
      t_nxt.n = t1_r.n + 1'b1;
      go = (t_nxt.n < max_it) && (mag < 66'(LIMIT));
      t_nxt.done = !go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld1_r;
    end
    tok_o <= t_nxt;
  end
endmodule

// ===== src/escape_time_fractal_pixel.sv =====
// escape-time fractal pixel engine (mandelbrot or julia, q8.24)
// input channel: in_tdata carries column and row; a request is taken on
// in_tvalid && in_tready. output channel: out_tdata carries the pixel
// indices and the iteration count, held until out_tready.
// configuration: cfg_we writes register cfg_addr with cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it. the
// core is a ring of 4 cells, each doing one iteration in a squares stage and
// an update stage; one pass through the cells and the ring register does 4
// iterations. one pixel is in flight at a time: the accepted column and row
// are registered and scaled by the steps, then the point enters cell 0.
// reset (rst_n low, synchronous) restores register defaults and empties
// the engine. a stalled receiver holds the result in the output register;
// the next request is taken once it leaves.
module escape_time_fractal_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // column[10:0], row[21:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // out_column[10:0], out_row[21:11], count[33:22]
  input  logic        cfg_we,
  input  logic [etf_pkg::REG_W-1:0] cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import etf_pkg::*;
  logic mode_r;
  logic [CNT_W-1:0] maxit_r;
  logic signed [QW-1:0] jre_r, jim_r, ore_r, oim_r;
  logic [STEP_W-1:0] sre_r, sim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; maxit_r <= 12'd128; jre_r <= '0; jim_r <= '0;
      ore_r <= -32'sd33554432; oim_r <= -32'sd16777216;
      sre_r <= 31'd16384; sim_r <= 31'd16384;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        R_MODE:  mode_r <= cfg_wdata[0];
        R_MAXIT: maxit_r <= cfg_wdata[CNT_W-1:0];
        R_JRE:   jre_r <= cfg_wdata;
        R_JIM:   jim_r <= cfg_wdata;
        R_ORE:   ore_r <= cfg_wdata;
        R_OIM:   oim_r <= cfg_wdata;
        R_SRE:   sre_r <= cfg_wdata[STEP_W-1:0];
        R_SIM:   sim_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic busy_r;
  logic [1:0] pv_r;
  logic [IDX_W-1:0] col_r, row_r;
  logic [41:0] mre_r, mim_r;
  logic signed [QW-1:0] pre, pim;
  tok_t tin, t [NCELL+1];
  logic v [NCELL+1];
  logic ring_v_r;
  tok_t ring_r;
  logic ovld_r;
  logic [CNT_W-1:0] ocnt_r;
  logic [IDX_W-1:0] ocol_r, orow_r;

  assign in_tready = !busy_r;
  assign pre = sat(66'(ore_r) + 66'(mre_r));
  assign pim = sat(66'(oim_r) + 66'(mim_r));

  always_comb begin
    tin.col = col_r; tin.row = row_r; tin.n = '0;
    tin.a = pre; tin.b = pim;
    tin.cre = mode_r ? jre_r : pre;
    tin.cim = mode_r ? jim_r : pim;
    tin.done = 1'b0;
    t[0] = pv_r[1] ? tin : ring_r;
    v[0] = pv_r[1] | ring_v_r;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    etf_cell u_cell (.clk, .rst_n, .vld_i(v[i]), .tok_i(t[i]), .max_it(maxit_r),
                     .vld_o(v[i+1]), .tok_o(t[i+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; pv_r <= '0; ring_v_r <= 1'b0; ovld_r <= 1'b0;
    end else begin
      pv_r <= {pv_r[0], in_tvalid && in_tready};
      if (in_tvalid && in_tready) busy_r <= 1'b1;
      ring_v_r <= v[NCELL] && !t[NCELL].done;
      if (v[NCELL] && t[NCELL].done) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
      if (ovld_r && out_tready) busy_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      col_r <= in_tdata[IDX_W-1:0];
      row_r <= in_tdata[2*IDX_W-1:IDX_W];
    end
    mre_r <= 42'(col_r) * 42'(sre_r);
    mim_r <= 42'(row_r) * 42'(sim_r);
    ring_r <= t[NCELL];
    if (v[NCELL] && t[NCELL].done) begin
      ocol_r <= t[NCELL].col; orow_r <= t[NCELL].row; ocnt_r <= t[NCELL].n;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {6'd0, ocnt_r, orow_r, ocol_r};
endmodule
